// ----- rtl/zclp_pkg.sv -----
// zclp_pkg: shared types and constants for the zone command line parser
// parse phase encoding, frame kind codes and character constants
// no dependencies
`default_nettype none

package zclp_pkg;

  // parse phase of the line being received
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CMD_UNIT = 4'd1,
    PH_CMD_ZONE = 4'd2,
    PH_CMD_C1   = 4'd3,
    PH_CMD_C2   = 4'd4,
    PH_CMD_V10  = 4'd5,
    PH_CMD_V1   = 4'd6,
    PH_CMD_DONE = 4'd7,
    PH_QRY_UNIT = 4'd8,
    PH_QRY_ZONE = 4'd9,
    PH_QRY_C1   = 4'd10,
    PH_QRY_C2   = 4'd11,
    PH_QRY_DONE = 4'd12
  } phase_t;

  localparam int KindWidth = 3;
  typedef logic [KindWidth-1:0] kind_t;

  localparam kind_t KIND_DISCARD = 3'd0;
  localparam kind_t KIND_SET     = 3'd1;
  localparam kind_t KIND_ZSTAT   = 3'd2;
  localparam kind_t KIND_QUERY   = 3'd3;
  localparam kind_t KIND_DEBUG   = 3'd4;

  localparam logic [7:0] CHR_CMD     = 8'h3C;  // '<'
  localparam logic [7:0] CHR_QRY     = 8'h3F;  // '?'
  localparam logic [7:0] CHR_CR      = 8'h0D;  // carriage return
  localparam logic [7:0] CASE_MASK   = 8'h5F;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_ONE     = 8'h31;
  localparam logic [7:0] CHR_FOUR    = 8'h34;
  localparam logic [7:0] CHR_SIX     = 8'h36;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_UP_A    = 8'h41;
  localparam logic [7:0] CHR_UP_Z    = 8'h5A;
  localparam logic [7:0] CHR_LO_A    = 8'h61;
  localparam logic [7:0] CHR_LO_Z    = 8'h7A;

endpackage

`default_nettype wire

// ----- rtl/zone_command_line_parser_top.sv -----
// zone_command_line_parser_top: byte-wise line parser for zone set commands and queries
// depends on zclp_pkg for phase encoding, frame kinds and character constants
`default_nettype none

// One received byte per transaction on the rx channel; lower case letters are
// folded to upper case first. Set lines are '<' unit(1-4) zone(0-6) two letters
// and two decimal digits; query lines are '?' unit(0-4) zone(0-6) with an
// optional letter pair. A byte that does not fit the current position drops the
// parser back to idle. Each carriage return produces exactly one frame
// transaction (discarded, set, zone status, single query or debug dump) and
// returns to idle; every other byte produces none. Unless rx_stall is raised,
// one byte per clock is taken: state and frame fields are updated by a single
// level of logic from the accepted byte into the phase and store registers and
// the frame output register. The output register holds one frame; rx_stall is
// raised only for a carriage return that arrives while a previous frame is
// still held and stalled downstream, so ordinary bytes keep flowing meanwhile.
module zone_command_line_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            frame_valid,
  input  wire logic       frame_stall,
  output zclp_pkg::kind_t frame_kind,
  output logic [2:0]      unit_number,
  output logic [2:0]      zone_digit,
  output logic [4:0]      virtual_zone,
  output logic [6:0]      code_first,
  output logic [6:0]      code_second,
  output logic [6:0]      control_value
);
  import zclp_pkg::*;

  // parser state
  phase_t     phase, phase_next;
  logic [2:0] unit_store, unit_store_next;
  logic [2:0] zone_store, zone_store_next;
  logic [6:0] code_first_store, code_first_store_next;
  logic [6:0] code_second_store, code_second_store_next;
  logic [6:0] value_store, value_store_next;

  // folded byte and character classes
  logic [7:0] ch;
  logic       is_cr, is_upper, is_digit;
  logic [3:0] digit;
  logic       accept;
  logic       emit;

  // frame built from the stores on a carriage return
  kind_t      kind_new;
  logic       with_code, with_value;
  logic [4:0] vz_new;
  logic [2:0] unit_m1;

  always_comb begin
    if (rx_byte >= CHR_LO_A && rx_byte <= CHR_LO_Z) begin
      ch = rx_byte & CASE_MASK;
    end else begin
      ch = rx_byte;
    end
  end

  assign is_cr    = (ch == CHR_CR);
  assign is_upper = (ch >= CHR_UP_A) && (ch <= CHR_UP_Z);
  assign is_digit = (ch >= CHR_ZERO) && (ch <= CHR_NINE);
  assign digit    = ch[3:0];

  // only a return needs the output register; hold it off while a frame waits
  assign rx_stall = frame_valid && frame_stall && is_cr;
  assign accept   = rx_valid && !rx_stall;
  assign emit     = accept && is_cr;

  // next parser state for a non-return byte
  always_comb begin
    phase_next             = PH_IDLE;
    unit_store_next        = unit_store;
    zone_store_next        = zone_store;
    code_first_store_next  = code_first_store;
    code_second_store_next = code_second_store;
    value_store_next       = value_store;
    case (phase)
      PH_IDLE: begin
        unit_store_next        = '0;
        zone_store_next        = '0;
        code_first_store_next  = '0;
        code_second_store_next = '0;
        value_store_next       = '0;
        if (ch == CHR_CMD) begin
          phase_next = PH_CMD_UNIT;
        end else if (ch == CHR_QRY) begin
          phase_next = PH_QRY_UNIT;
        end
      end
      PH_CMD_UNIT, PH_QRY_UNIT: begin
        if (ch >= ((phase == PH_CMD_UNIT) ? CHR_ONE : CHR_ZERO) && ch <= CHR_FOUR) begin
          unit_store_next = ch[2:0];
          phase_next      = (phase == PH_CMD_UNIT) ? PH_CMD_ZONE : PH_QRY_ZONE;
        end
      end
      PH_CMD_ZONE, PH_QRY_ZONE: begin
        if (ch >= CHR_ZERO && ch <= CHR_SIX) begin
          zone_store_next = ch[2:0];
          phase_next      = (phase == PH_CMD_ZONE) ? PH_CMD_C1 : PH_QRY_C1;
        end
      end
      PH_CMD_C1, PH_QRY_C1: begin
        if (is_upper) begin
          code_first_store_next = ch[6:0];
          phase_next            = (phase == PH_CMD_C1) ? PH_CMD_C2 : PH_QRY_C2;
        end
      end
      PH_CMD_C2, PH_QRY_C2: begin
        if (is_upper) begin
          code_second_store_next = ch[6:0];
          phase_next             = (phase == PH_CMD_C2) ? PH_CMD_V10 : PH_QRY_DONE;
        end
      end
      PH_CMD_V10: begin
        if (is_digit) begin
          // tens digit times ten as two shifts
          value_store_next = {digit, 3'b000} + {2'b00, digit, 1'b0};
          phase_next       = PH_CMD_V1;
        end
      end
      PH_CMD_V1: begin
        if (is_digit) begin
          value_store_next = value_store + {3'b000, digit};
          phase_next       = PH_CMD_DONE;
        end
      end
      default: begin
        // complete lines and unused codes fall back to idle
        phase_next = PH_IDLE;
      end
    endcase
  end

  // frame kind for the return, taken from the phase before it
  always_comb begin
    kind_new   = KIND_DISCARD;
    with_code  = 1'b0;
    with_value = 1'b0;
    case (phase)
      PH_CMD_DONE: begin
        kind_new   = KIND_SET;
        with_code  = 1'b1;
        with_value = 1'b1;
      end
      PH_QRY_C1: begin
        kind_new = (unit_store == 3'd0 && zone_store == 3'd0) ? KIND_DEBUG : KIND_ZSTAT;
      end
      PH_QRY_DONE: begin
        kind_new  = KIND_QUERY;
        with_code = 1'b1;
      end
      default: begin
        kind_new = KIND_DISCARD;
      end
    endcase
  end

  // virtual zone (unit-1)*6+zone, zero for whole-unit or unit 0
  assign unit_m1 = unit_store - 3'd1;
  always_comb begin
    if (unit_store >= 3'd1 && unit_store <= 3'd4 && zone_store >= 3'd1 && zone_store <= 3'd6)
    begin
      vz_new = {unit_m1, 2'b00} + {1'b0, unit_m1, 1'b0} + {2'b00, zone_store};
    end else begin
      vz_new = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      unit_store        <= '0;
      zone_store        <= '0;
      code_first_store  <= '0;
      code_second_store <= '0;
      value_store       <= '0;
    end else if (accept) begin
      if (is_cr) begin
        phase <= PH_IDLE;
      end else begin
        phase             <= phase_next;
        unit_store        <= unit_store_next;
        zone_store        <= zone_store_next;
        code_first_store  <= code_first_store_next;
        code_second_store <= code_second_store_next;
        value_store       <= value_store_next;
      end
    end
  end

  // frame output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (emit) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  // frame payload, loaded only when a return is accepted
  always_ff @(posedge clk) begin
    if (emit) begin
      frame_kind <= kind_new;
      if (kind_new == KIND_DISCARD) begin
        unit_number   <= '0;
        zone_digit    <= '0;
        virtual_zone  <= '0;
        code_first    <= '0;
        code_second   <= '0;
        control_value <= '0;
      end else begin
        unit_number   <= unit_store;
        zone_digit    <= zone_store;
        virtual_zone  <= vz_new;
        code_first    <= with_code ? code_first_store : 7'd0;
        code_second   <= with_code ? code_second_store : 7'd0;
        control_value <= with_value ? value_store : 7'd0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim/zone_command_line_parser_top_test.sv -----
// zone_command_line_parser_top_test: self-checking bench for the zone command line parser
// drives byte lines on rx, checks every frame against a typed frame or the line decoder
// depends on zclp_pkg and zone_command_line_parser_top
`timescale 1ns / 1ps

module zone_command_line_parser_top_test;
  import zclp_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int HoldCycles   = 400;
  localparam int IdlePercent  = 34;
  localparam int RandomBytes  = 1300;
  localparam int DrainCycles  = 20;

  // one decoded frame, field for field as on the output ports
  typedef struct packed {
    kind_t      kind;
    logic [2:0] unit;
    logic [2:0] zone;
    logic [4:0] vzone;
    logic [6:0] code1;
    logic [6:0] code2;
    logic [6:0] value;
  } line_frame_t;

  // one row of the directed stimulus: byte, and the frame typed in by hand if any
  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    line_frame_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // rx channel
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;

  // frame channel
  logic       frame_valid;
  logic       frame_stall = 1'b0;
  kind_t      frame_kind;
  logic [2:0] unit_number;
  logic [2:0] zone_digit;
  logic [4:0] virtual_zone;
  logic [6:0] code_first;
  logic [6:0] code_second;
  logic [6:0] control_value;

  // pressure control; quiet and hold_start written nonblocking by the stimulus process
  logic quiet      = 1'b0;
  logic hold_start = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  int cycle_count    = 0;
  int mismatch_count = 0;

  // frames the decoder has promised and the block has not delivered yet
  line_frame_t pending_frames[$];
  dir_row_t    dir_tab[$];
  logic [7:0]  line_bytes[$];

  // line decoder state, mirrors the block's phase and stores
  phase_t     phase_r = PH_IDLE;
  logic [2:0] unit_r  = '0;
  logic [2:0] zone_r  = '0;
  logic [6:0] code1_r = '0;
  logic [6:0] code2_r = '0;
  logic [6:0] value_r = '0;

  zone_command_line_parser_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_kind   (frame_kind),
    .unit_number  (unit_number),
    .zone_digit   (zone_digit),
    .virtual_zone (virtual_zone),
    .code_first   (code_first),
    .code_second  (code_second),
    .control_value(control_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // line decoder
  // ---------------------------------------------------------------------------

  // frame from the current stores; virtual zone only for units 1-4 and zones 1-6
  function automatic line_frame_t build_frame(kind_t kind, bit with_code, bit with_value);
    line_frame_t f;
    f       = '0;
    f.kind  = kind;
    f.unit  = unit_r;
    f.zone  = zone_r;
    if (unit_r >= 3'd1 && unit_r <= 3'd4 && zone_r >= 3'd1 && zone_r <= 3'd6) begin
      f.vzone = 5'((unit_r - 1) * 6 + zone_r);
    end
    f.code1 = with_code ? code1_r : 7'd0;
    f.code2 = with_code ? code2_r : 7'd0;
    f.value = with_value ? value_r : 7'd0;
    return f;
  endfunction

  // advance the decoder by one accepted byte; returns 1 when a frame is due
  function automatic bit parse_byte(input logic [7:0] raw, output line_frame_t f);
    logic [7:0] c;
    phase_t     nxt;
    c   = raw;
    f   = '0;
    nxt = PH_IDLE;
    // lower case letters fold to upper case before anything else
    if (c >= CHR_LO_A && c <= CHR_LO_Z) c = c & CASE_MASK;

    // carriage return always closes the line with exactly one frame
    if (c == CHR_CR) begin
      case (phase_r)
        PH_CMD_DONE: f = build_frame(KIND_SET, 1'b1, 1'b1);
        PH_QRY_C1: begin
          // query without code: unit 0 zone 0 is the debug dump
          f = build_frame((unit_r == 3'd0 && zone_r == 3'd0) ? KIND_DEBUG : KIND_ZSTAT,
                          1'b0, 1'b0);
        end
        PH_QRY_DONE: f = build_frame(KIND_QUERY, 1'b1, 1'b0);
        default:     f = '0;  // incomplete line is discarded with all fields zero
      endcase
      phase_r = PH_IDLE;
      return 1'b1;
    end

    // any byte not allowed at the current position leaves nxt at idle
    case (phase_r)
      PH_IDLE: begin
        // stores clear on every byte seen in idle
        unit_r  = '0;
        zone_r  = '0;
        code1_r = '0;
        code2_r = '0;
        value_r = '0;
        if (c == CHR_CMD) nxt = PH_CMD_UNIT;
        else if (c == CHR_QRY) nxt = PH_QRY_UNIT;
      end
      PH_CMD_UNIT: begin
        if (c >= CHR_ONE && c <= CHR_FOUR) begin
          unit_r = 3'(c - CHR_ZERO);
          nxt    = PH_CMD_ZONE;
        end
      end
      PH_QRY_UNIT: begin
        if (c >= CHR_ZERO && c <= CHR_FOUR) begin
          unit_r = 3'(c - CHR_ZERO);
          nxt    = PH_QRY_ZONE;
        end
      end
      PH_CMD_ZONE, PH_QRY_ZONE: begin
        if (c >= CHR_ZERO && c <= CHR_SIX) begin
          zone_r = 3'(c - CHR_ZERO);
          nxt    = (phase_r == PH_CMD_ZONE) ? PH_CMD_C1 : PH_QRY_C1;
        end
      end
      PH_CMD_C1, PH_QRY_C1: begin
        if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
          code1_r = c[6:0];
          nxt     = (phase_r == PH_CMD_C1) ? PH_CMD_C2 : PH_QRY_C2;
        end
      end
      PH_CMD_C2, PH_QRY_C2: begin
        if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
          code2_r = c[6:0];
          nxt     = (phase_r == PH_CMD_C2) ? PH_CMD_V10 : PH_QRY_DONE;
        end
      end
      PH_CMD_V10: begin
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
          value_r = 7'(10 * (c - CHR_ZERO));
          nxt     = PH_CMD_V1;
        end
      end
      PH_CMD_V1: begin
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
          value_r = 7'(value_r + (c - CHR_ZERO));
          nxt     = PH_CMD_DONE;
        end
      end
      default: ;  // a byte after a complete line also lands here and goes idle
    endcase
    phase_r = nxt;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // rx side
  // ---------------------------------------------------------------------------

  // offer one byte, hold it through stalls, then feed the accepted byte to the decoder
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input line_frame_t want = '0);
    line_frame_t f;
    // random idle cycles, skipped during the quiet stretch
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    if (parse_byte(b, f)) pending_frames.push_back(typed ? want : f);
  endtask

  task automatic add_row(input logic [7:0] b, input bit typed = 1'b0,
                         input line_frame_t want = '0);
    dir_row_t r;
    r.rx    = b;
    r.typed = typed;
    r.want  = want;
    dir_tab.push_back(r);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? CHR_UP_A : CHR_LO_A;
    return base + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit(int lo, int hi);
    return CHR_ZERO + 8'($urandom_range(hi, lo));
  endfunction

  // well-formed set or query line without the closing return
  task automatic put_wellformed(input bit is_set);
    if (is_set) begin
      line_bytes.push_back(CHR_CMD);
      line_bytes.push_back(rand_digit(1, 4));
      line_bytes.push_back(rand_digit(0, 6));
      line_bytes.push_back(rand_letter());
      line_bytes.push_back(rand_letter());
      line_bytes.push_back(rand_digit(0, 9));
      line_bytes.push_back(rand_digit(0, 9));
    end else begin
      line_bytes.push_back(CHR_QRY);
      // unit 0 zone 0 shows up often enough to hit the debug dump
      if ($urandom_range(5) == 0) begin
        line_bytes.push_back(CHR_ZERO);
        line_bytes.push_back(CHR_ZERO);
      end else begin
        line_bytes.push_back(rand_digit(0, 4));
        line_bytes.push_back(rand_digit(0, 6));
      end
      if ($urandom_range(1)) begin
        line_bytes.push_back(rand_letter());
        line_bytes.push_back(rand_letter());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // frame side
  // ---------------------------------------------------------------------------

  // random stall, a long hold-off once the stimulus asks for it, none while quiet
  always @(posedge clk) begin
    if (hold_left != 0) begin
      frame_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_start && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HoldCycles - 1;
      frame_stall <= 1'b1;
    end else begin
      frame_stall <= !quiet && ($urandom_range(99) < IdlePercent);
    end
  end

  task automatic check_field(input string name, input logic [6:0] want,
                             input logic [6:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // every accepted frame is matched against the oldest pending one
  always @(posedge clk) begin
    line_frame_t exp_f;
    if (!rst && frame_valid && !frame_stall) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: frame with none pending, actual kind %0d", $time, frame_kind);
        mismatch_count++;
      end else begin
        exp_f = pending_frames.pop_front();
        check_field("frame_kind", 7'(exp_f.kind), 7'(frame_kind));
        check_field("unit_number", 7'(exp_f.unit), 7'(unit_number));
        check_field("zone_digit", 7'(exp_f.zone), 7'(zone_digit));
        check_field("virtual_zone", 7'(exp_f.vzone), 7'(virtual_zone));
        check_field("code_first", exp_f.code1, code_first);
        check_field("code_second", exp_f.code2, code_second);
        check_field("control_value", exp_f.value, control_value);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int  sent;
    int  style;
    int  pos;
    bit  hold_armed;
    bit  quiet_done;

    sent       = 0;
    hold_armed = 1'b0;
    quiet_done = 1'b0;

    // directed lines: return right after reset
    add_row(CHR_CR, 1'b1, '0);
    // set line at the top of every field but the second letter, lower case letter folded
    add_row(CHR_CMD);
    add_row(CHR_FOUR);
    add_row(CHR_SIX);
    add_row(CHR_LO_Z);
    add_row(CHR_UP_A);
    add_row(CHR_NINE);
    add_row(CHR_NINE);
    add_row(CHR_CR, 1'b1, '{KIND_SET, 3'd4, 3'd6, 5'd24, 7'h5A, 7'h41, 7'd99});
    // query to unit 0 zone 0 without code is the debug dump
    add_row(CHR_QRY);
    add_row(CHR_ZERO);
    add_row(CHR_ZERO);
    add_row(CHR_CR, 1'b1, '{KIND_DEBUG, 3'd0, 3'd0, 5'd0, 7'd0, 7'd0, 7'd0});
    // single query to unit 0 with a nonzero zone keeps virtual zone at 0
    add_row(CHR_QRY);
    add_row(CHR_ZERO);
    add_row(8'h33);
    add_row(8'h71);
    add_row(8'h62);
    add_row(CHR_CR, 1'b1, '{KIND_QUERY, 3'd0, 3'd3, 5'd0, 7'h51, 7'h42, 7'd0});
    // disallowed byte in the middle of a set line, then return discards
    add_row(CHR_CMD);
    add_row(CHR_ONE);
    add_row(8'hFF);
    add_row(CHR_CR, 1'b1, '0);
    // whole-unit zone status
    add_row(CHR_QRY);
    add_row(CHR_ONE);
    add_row(CHR_ZERO);
    add_row(CHR_CR);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].want);

    // random lines: mostly well-formed, some broken, some pure noise
    while (sent < RandomBytes) begin
      line_bytes.delete();
      style = $urandom_range(99);
      if (style < 40) begin
        put_wellformed(1'b1);
      end else if (style < 72) begin
        put_wellformed(1'b0);
      end else if (style < 90) begin
        put_wellformed(1'($urandom_range(1)));
        pos = $urandom_range(line_bytes.size() - 1);
        case ($urandom_range(2))
          0: while (line_bytes.size() > pos) void'(line_bytes.pop_back());
          1: line_bytes[pos] = 8'($urandom_range(255));
          default: line_bytes.push_back(8'($urandom_range(255)));  // byte after full line
        endcase
      end else begin
        repeat ($urandom_range(6, 1)) line_bytes.push_back(8'($urandom_range(255)));
      end
      line_bytes.push_back(CHR_CR);
      if ($urandom_range(9) == 0) line_bytes.push_back(CHR_CR);  // return while idle

      sent += line_bytes.size();

      // quiet stretch with one long hold-off on the frame side
      if (!hold_armed && sent >= 300) begin
        hold_armed = 1'b1;
        quiet      <= 1'b1;
        hold_start <= 1'b1;
      end else if (hold_armed && !quiet_done && sent >= 700) begin
        quiet_done = 1'b1;
        quiet      <= 1'b0;
      end

      foreach (line_bytes[i]) send_byte(line_bytes[i]);
    end

    rx_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
